[design/htw_pkg.sv]
// Package for the Huffman tree-walk decoder: node entry layout, field widths,
// request and register codes, controller states and the command/status bundles.
// Has no dependencies; the decoder top, htw_ctrl, htw_dpath and the testbench import it.
`default_nettype none

package htw_pkg;

  // Field widths fixed by the stream format.
  localparam int NODE_W     = 9;
  localparam int SYM_W      = 8;
  localparam int BYTE_W     = 8;
  localparam int CNT32_W    = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;

  // Default sizing handed down from the top level.
  localparam int DEF_TREE_NODES = 511;

  // Coded bits walked per decode transaction; the coded field is one byte.
  localparam int CODED_BITS = BYTE_W;

  // Bit offsets of the input fields inside in_tdata.
  localparam int OFS_ADDR  = 0;
  localparam int OFS_ZERO  = 9;
  localparam int OFS_ONE   = 18;
  localparam int OFS_LEAF  = 27;
  localparam int OFS_SYM   = 28;
  localparam int OFS_CODED = 36;

  // Request kinds carried on in_tuser.
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_DECODE = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ROOT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 1'b1;

  // One stored tree node, zero branch in the lowest bits.
  typedef struct packed {
    logic [SYM_W-1:0]  sym;
    logic              leaf;
    logic [NODE_W-1:0] one_br;
    logic [NODE_W-1:0] zero_br;
  } node_t;

  localparam int NODE_ENTRY_W = $bits(node_t);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WALK,
    ST_FLUSH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_node;
    logic load_coded;
    logic start_rd;
    logic walk;
    logic flush;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_done;
    logic flush_done;
  } sts_t;

endpackage

`default_nettype wire

[design/huffman_tree_walk_decoder.sv]
// Huffman tree-walk decoder over a stored code tree.
//
// Input stream (in_*): tuser selects the transaction kind. A load transaction
// writes one tree node and leaves the block idle. A decode transaction carries one
// coded byte whose bits are walked most significant first through the tree.
// Output stream (out_*): one transaction per leaf reached, tlast on the last
// symbol of a coded byte; a byte that reaches no leaf produces nothing.
// Configuration (cfg_*): index 0 is the root node, index 1 the total number of
// coded bits in the stream; writes are always accepted and are registered.
// A decode transaction holds off further input until it completes: the block
// re-reads the node where the walk stands, reads the tree store once per coded
// bit within the bit budget (each read depends on the last), checks the final
// node for a leaf and then releases the last symbol.
// One symbol is held back to learn whether it is the last of its byte; when the
// receiver stalls, the walk stops at the next leaf and resumes once the output
// register drains. Reset clears the walk to the root, the bit count and the control
// registers; tree contents are undefined until loaded.
// Depends on htw_pkg, htw_ctrl, htw_dpath and htw_ram.
`default_nettype none

module huffman_tree_walk_decoder #(
  parameter int TREE_NODES = htw_pkg::DEF_TREE_NODES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // in_tdata, low bit up: node_addr[8:0], zero_branch[17:9], one_branch[26:18],
  // is_leaf[27], leaf_symbol[35:28], coded_byte[43:36], zero fill[47:44]
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [htw_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic                            in_tuser,   // req_type
  // out_tdata, low bit up: decoded_symbol[7:0]
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [htw_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                 out_tlast,  // run_last
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [htw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [htw_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import htw_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  htw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .cmd       (cmd),
    .sts       (sts)
  );

  htw_dpath #(
    .TREE_NODES (TREE_NODES)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire

[design/htw_ram.sv]
// Generic RAM with one write port and two registered read ports.
// Standalone; read data holds while its read enable is low.
`default_nettype none

module htw_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 511
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic                     re_b,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read ports.
  always_ff @(posedge clk) begin
    if (re_a) begin
      rdata_a <= mem[raddr_a];
    end
    if (re_b) begin
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

`default_nettype wire

[design/htw_ctrl.sv]
// Controller state machine of the Huffman tree-walk decoder.
// Depends on htw_pkg; drives commands to htw_dpath and reads its status.
`default_nettype none

module htw_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_tuser,
  output logic               in_tready,
  output htw_pkg::cmd_t      cmd,
  input  wire htw_pkg::sts_t sts
);
  import htw_pkg::*;

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser == REQ_DECODE) begin
            cmd.load_coded = 1'b1;
            state_nxt      = ST_START;
          end else begin
            cmd.load_node = 1'b1;
          end
        end
      end
      ST_START: begin
        cmd.start_rd = 1'b1;
        state_nxt    = ST_WALK;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush = 1'b1;
        if (sts.flush_done) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[design/htw_dpath.sv]
// Datapath of the Huffman tree-walk decoder: tree store, walk registers,
// configuration registers, symbol hold stage and output register.
// Depends on htw_pkg and htw_ram; commanded by htw_ctrl.
`default_nettype none

module htw_dpath #(
  parameter int TREE_NODES = htw_pkg::DEF_TREE_NODES
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire htw_pkg::cmd_t                   cmd,
  output htw_pkg::sts_t                        sts,
  input  wire logic [htw_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic                            cfg_valid,
  input  wire logic [htw_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [htw_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            out_tready,
  output logic                                 out_tvalid,
  output logic [htw_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                 out_tlast
);
  import htw_pkg::*;

  localparam int AW    = $clog2(TREE_NODES);
  localparam int CW    = CODED_BITS;
  localparam int CNT_W = $clog2(CODED_BITS + 1);
  localparam logic [NODE_W-1:0] NODE_LIMIT = NODE_W'(TREE_NODES);

  // Input fields.
  logic [NODE_W-1:0] f_addr;
  node_t             f_node;
  logic [BYTE_W-1:0] f_coded;

  assign f_addr         = in_tdata[OFS_ADDR +: NODE_W];
  assign f_node.zero_br = in_tdata[OFS_ZERO +: NODE_W];
  assign f_node.one_br  = in_tdata[OFS_ONE +: NODE_W];
  assign f_node.leaf    = in_tdata[OFS_LEAF];
  assign f_node.sym     = in_tdata[OFS_SYM +: SYM_W];
  assign f_coded        = in_tdata[OFS_CODED +: BYTE_W];

  // Registers.
  logic [NODE_W-1:0]  root_node_r, root_node_nxt;
  logic [CNT32_W-1:0] total_bits_r, total_bits_nxt;
  logic [NODE_W-1:0]  walk_node_r, walk_node_nxt;
  logic               at_root_r, at_root_nxt;
  logic [CNT32_W-1:0] bits_used_r, bits_used_nxt;
  logic [CW-1:0]      coded_r, coded_nxt;
  logic [CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic               pending_r, pending_nxt;
  logic [SYM_W-1:0]   hold_sym_r, hold_sym_nxt;
  logic               hold_vld_r, hold_vld_nxt;
  logic [SYM_W-1:0]   out_sym_r, out_sym_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic               a_oor_r, a_oor_nxt;
  logic               b_oor_r;

  // Tree store signals.
  logic                    ram_we;
  logic                    re_a;
  logic [NODE_W-1:0]       rd_idx_a;
  logic [NODE_ENTRY_W-1:0] a_raw, b_raw;
  node_t                   a_ent, b_ent, cur_ent;

  // Walk control.
  logic              leaf_now, need_push, out_free, stall;
  logic              bits_done, advance, do_bit, at_root_eff;
  logic              coded_bit;
  logic [NODE_W-1:0] nxt_node;
  logic              push_walk, push_flush;

  htw_ram #(
    .WIDTH (NODE_ENTRY_W),
    .DEPTH (TREE_NODES)
  ) u_tree (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (f_addr[AW-1:0]),
    .wdata   (f_node),
    .re_a    (re_a),
    .raddr_a (rd_idx_a[AW-1:0]),
    .rdata_a (a_raw),
    .re_b    (1'b1),
    .raddr_b (root_node_r[AW-1:0]),
    .rdata_b (b_raw)
  );

  // Loads beyond the store are dropped; reads beyond it see an empty node.
  assign ram_we = cmd.load_node && (f_addr < NODE_LIMIT);
  assign a_ent  = a_oor_r ? '0 : node_t'(a_raw);
  assign b_ent  = b_oor_r ? '0 : node_t'(b_raw);

  // Leaf check of the previous step and the step for the current bit.
  assign leaf_now    = pending_r && a_ent.leaf;
  assign need_push   = leaf_now && hold_vld_r;
  assign out_free    = !out_vld_r || out_tready;
  assign stall       = need_push && !out_free;
  assign bits_done   = (bit_cnt_r == CNT_W'(CODED_BITS)) || (bits_used_r >= total_bits_r);
  assign advance     = cmd.walk && !stall;
  assign do_bit      = advance && !bits_done;
  assign at_root_eff = leaf_now || at_root_r;
  assign cur_ent     = at_root_eff ? b_ent : a_ent;
  assign coded_bit   = coded_r[CW-1];
  assign nxt_node    = coded_bit ? cur_ent.one_br : cur_ent.zero_br;
  assign push_walk   = advance && need_push;
  assign push_flush  = cmd.flush && hold_vld_r && out_free;

  // Port A reads the resumed node at item start, then each branch taken.
  assign re_a      = cmd.start_rd || do_bit;
  assign rd_idx_a  = cmd.start_rd ? walk_node_r : nxt_node;
  assign a_oor_nxt = re_a ? (rd_idx_a >= NODE_LIMIT) : a_oor_r;

  assign sts.walk_done  = bits_done && !stall;
  assign sts.flush_done = !hold_vld_r || out_free;

  // Next-state logic of the walk, hold stage and output register.
  always_comb begin
    root_node_nxt  = root_node_r;
    total_bits_nxt = total_bits_r;
    walk_node_nxt  = walk_node_r;
    at_root_nxt    = at_root_r;
    bits_used_nxt  = bits_used_r;
    coded_nxt      = coded_r;
    bit_cnt_nxt    = bit_cnt_r;
    pending_nxt    = pending_r;
    hold_sym_nxt   = hold_sym_r;
    hold_vld_nxt   = hold_vld_r;
    out_sym_nxt    = out_sym_r;
    out_last_nxt   = out_last_r;
    out_vld_nxt    = out_vld_r && !out_tready;

    // Configuration writes.
    if (cfg_valid) begin
      case (cfg_index)
        REG_ROOT:  root_node_nxt  = cfg_data[NODE_W-1:0];
        REG_TOTAL: total_bits_nxt = cfg_data;
        default:   ;
      endcase
    end

    // New coded byte.
    if (cmd.load_coded) begin
      coded_nxt   = CW'(f_coded);
      bit_cnt_nxt = '0;
      pending_nxt = 1'b0;
    end

    // One walk step per cycle while the output does not stall the walk.
    if (advance) begin
      pending_nxt = do_bit;
      if (leaf_now) begin
        at_root_nxt  = 1'b1;
        hold_sym_nxt = a_ent.sym;
        hold_vld_nxt = 1'b1;
      end
      if (do_bit) begin
        walk_node_nxt = nxt_node;
        at_root_nxt   = 1'b0;
        bits_used_nxt = bits_used_r + 32'd1;
        coded_nxt     = coded_r << 1;
        bit_cnt_nxt   = bit_cnt_r + CNT_W'(1);
      end
    end

    // A held symbol goes out once the next one is known or the item ends.
    if (push_walk) begin
      out_sym_nxt  = hold_sym_r;
      out_last_nxt = 1'b0;
      out_vld_nxt  = 1'b1;
    end else if (push_flush) begin
      out_sym_nxt  = hold_sym_r;
      out_last_nxt = 1'b1;
      out_vld_nxt  = 1'b1;
      hold_vld_nxt = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_node_r  <= '0;
      total_bits_r <= '0;
      walk_node_r  <= '0;
      at_root_r    <= 1'b1;
      bits_used_r  <= '0;
      bit_cnt_r    <= '0;
      pending_r    <= 1'b0;
      hold_vld_r   <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      root_node_r  <= root_node_nxt;
      total_bits_r <= total_bits_nxt;
      walk_node_r  <= walk_node_nxt;
      at_root_r    <= at_root_nxt;
      bits_used_r  <= bits_used_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      pending_r    <= pending_nxt;
      hold_vld_r   <= hold_vld_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    coded_r    <= coded_nxt;
    hold_sym_r <= hold_sym_nxt;
    out_sym_r  <= out_sym_nxt;
    out_last_r <= out_last_nxt;
    a_oor_r    <= a_oor_nxt;
    b_oor_r    <= root_node_r >= NODE_LIMIT;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_sym_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[tb/huffman_tree_walk_decoder_test.sv]
// Self-checking testbench for huffman_tree_walk_decoder: it loads code trees, streams
// coded bytes and compares every decoded symbol with a tree walk kept inside the bench.
// Depends on htw_pkg and the decoder RTL.

module huffman_tree_walk_decoder_test;
  import htw_pkg::*;

  localparam int TREE_NODES    = DEF_TREE_NODES;
  localparam int ITEM_TARGET   = 460;
  localparam int SETTLE_CYCLES = CODED_BITS + 8;
  localparam int STALL_LIMIT   = 1000;
  localparam logic [CFG_DATA_W-1:0] ALL_BITS = '1;

  // One expected output transaction.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             is_last;
  } symbol_result_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = REQ_LOAD;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = REG_ROOT;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  // Bench copy of the decoder state and registers.
  node_t             tree_copy [0:TREE_NODES-1];
  bit                node_written [0:TREE_NODES-1];
  logic [NODE_W-1:0] walk_pos      = '0;
  logic              walk_at_root  = 1'b1;
  logic [31:0]       bits_consumed = '0;
  logic [NODE_W-1:0] root_reg      = '0;
  logic [31:0]       total_reg     = '0;

  symbol_result_t expected_symbols [$];
  symbol_result_t want;

  bit quiet_mode      = 1'b0;
  int error_count     = 0;
  int items_sent      = 0;
  int loads_sent      = 0;
  int bytes_sent      = 0;
  int symbols_checked = 0;
  int cfg_writes      = 0;
  int trees_built     = 0;
  int largest_tree    = 0;

  huffman_tree_walk_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Entries past the end of the store read back as an all-zero node.
  function automatic node_t read_tree(input logic [NODE_W-1:0] idx);
    if (int'(idx) < TREE_NODES) return tree_copy[idx];
    return '0;
  endfunction

  // A load writes one node unless its address lies beyond the store.
  function automatic void store_node(input logic [IN_DATA_W-1:0] word);
    logic [NODE_W-1:0] addr;
    addr = word[OFS_ADDR +: NODE_W];
    if (int'(addr) < TREE_NODES) begin
      tree_copy[addr].zero_br = word[OFS_ZERO +: NODE_W];
      tree_copy[addr].one_br  = word[OFS_ONE +: NODE_W];
      tree_copy[addr].leaf    = word[OFS_LEAF];
      tree_copy[addr].sym     = word[OFS_SYM +: SYM_W];
      node_written[addr]      = 1'b1;
    end
  endfunction

  // Walk the coded bits of one byte and queue every symbol they reach.
  function automatic void predict_symbols(input logic [BYTE_W-1:0] coded);
    symbol_result_t found [0:CODED_BITS-1];
    int count;
    logic [NODE_W-1:0] cur;
    node_t here;
    node_t there;
    count = 0;
    for (int b = CODED_BITS - 1; b >= 0; b--) begin
      if (bits_consumed < total_reg) begin
        cur = walk_at_root ? root_reg : walk_pos;
        here = read_tree(cur);
        walk_pos = coded[b] ? here.one_br : here.zero_br;
        walk_at_root = 1'b0;
        there = read_tree(walk_pos);
        if (there.leaf) begin
          found[count].sym = there.sym;
          found[count].is_last = 1'b0;
          count++;
          walk_at_root = 1'b1;
        end
        bits_consumed++;
      end
    end
    for (int i = 0; i < count; i++) begin
      if (i == count - 1) found[i].is_last = 1'b1;
      expected_symbols.push_back(found[i]);
    end
  endfunction

  // Random node that has been written, so a root or branch picked here is never an empty entry.
  function automatic logic [NODE_W-1:0] pick_written();
    int idx;
    do idx = $urandom_range(0, TREE_NODES - 1); while (!node_written[idx]);
    return NODE_W'(idx);
  endfunction

  // Send one input transaction after a random gap, none in quiet mode; tvalid stays high on return
  // so that a following item with no gap goes out back to back.
  task automatic send_request(input logic kind, input logic [NODE_W-1:0] addr,
                              input logic [NODE_W-1:0] zb, input logic [NODE_W-1:0] ob,
                              input logic leaf, input logic [SYM_W-1:0] sym,
                              input logic [BYTE_W-1:0] coded);
    int gap;
    logic [IN_DATA_W-1:0] word;
    gap = quiet_mode ? 0 : $urandom_range(0, 6);
    word = '0;
    word[OFS_ADDR +: NODE_W]  = addr;
    word[OFS_ZERO +: NODE_W]  = zb;
    word[OFS_ONE +: NODE_W]   = ob;
    word[OFS_LEAF]            = leaf;
    word[OFS_SYM +: SYM_W]    = sym;
    word[OFS_CODED +: BYTE_W] = coded;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= word;
    do @(posedge clk); while (!in_tready);
    if (kind == REQ_LOAD) begin
      store_node(word);
      loads_sent++;
    end else begin
      predict_symbols(coded);
      bytes_sent++;
    end
    items_sent++;
  endtask

  // Load transaction; the unused coded byte carries random bits.
  task automatic load_node(input logic [NODE_W-1:0] addr, input logic [NODE_W-1:0] zb,
                           input logic [NODE_W-1:0] ob, input logic leaf,
                           input logic [SYM_W-1:0] sym);
    send_request(REQ_LOAD, addr, zb, ob, leaf, sym, BYTE_W'($urandom_range(0, 255)));
  endtask

  // Decode transaction; the unused node fields carry random values.
  task automatic decode_byte(input logic [BYTE_W-1:0] coded);
    send_request(REQ_DECODE, NODE_W'($urandom_range(0, 510)),
                 NODE_W'($urandom_range(0, 510)), NODE_W'($urandom_range(0, 510)),
                 1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)), coded);
  endtask

  // Stop sending, wait for every expected symbol, then let a walk that emits
  // nothing run to its end.
  task automatic settle_idle();
    in_tvalid <= 1'b0;
    while (expected_symbols.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_ROOT) root_reg = value[NODE_W-1:0];
    else total_reg = value;
    cfg_writes++;
    @(posedge clk);
  endtask

  // Build a proper code tree: leaves at base and up, internal nodes after them,
  // so the root lands at base + 2 * leaves - 2.
  task automatic build_code_tree(input int leaves, input int base);
    int pool [$];
    int next_addr;
    int i;
    int a;
    int b;
    for (i = 0; i < leaves; i++) begin
      pool.push_back(base + i);
      load_node(NODE_W'(base + i), NODE_W'(base + $urandom_range(0, 2 * leaves - 2)),
                NODE_W'(base + $urandom_range(0, 2 * leaves - 2)), 1'b1,
                SYM_W'($urandom_range(0, 255)));
    end
    next_addr = base + leaves;
    while (pool.size() > 1) begin
      i = $urandom_range(0, pool.size() - 1);
      a = pool[i];
      pool.delete(i);
      i = $urandom_range(0, pool.size() - 1);
      b = pool[i];
      pool.delete(i);
      if ($urandom_range(0, 1) == 1)
        load_node(NODE_W'(next_addr), NODE_W'(a), NODE_W'(b), 1'b0, SYM_W'($urandom_range(0, 255)));
      else
        load_node(NODE_W'(next_addr), NODE_W'(b), NODE_W'(a), 1'b0, SYM_W'($urandom_range(0, 255)));
      pool.push_back(next_addr);
      next_addr++;
    end
    trees_built++;
    if (leaves > largest_tree) largest_tree = leaves;
  endtask

  // After reset the bit budget is zero, so a decode transaction yields nothing.
  task automatic test_reset_limit();
    load_node(0, 0, 0, 1'b1, 8'h00);
    decode_byte(8'hFF);
  endtask

  // Three-leaf tree: 00, 01 and 1; the last byte leaves the walk mid code.
  task automatic test_small_tree();
    load_node(1, 0, 1, 1'b1, 8'hFF);
    load_node(2, 0, 1, 1'b1, 8'h5A);
    load_node(3, 0, 1, 1'b0, 8'h00);
    load_node(4, 3, 2, 1'b0, 8'hFF);
    settle_idle();
    write_register(REG_ROOT, 4);
    write_register(REG_TOTAL, ALL_BITS);
    decode_byte(8'h00);
    decode_byte(8'hFF);
    decode_byte(8'h6C);
    decode_byte(8'hAA);
  endtask

  // Loads while the walk stands below the root, a load past the store, a
  // branch past the store, and a new root that only applies after the next leaf.
  task automatic test_root_change();
    load_node(510, 511, 2, 1'b0, 8'h81);
    load_node(511, 1, 1, 1'b1, 8'h33);
    settle_idle();
    write_register(REG_ROOT, 510);
    decode_byte(8'h80);
  endtask

  // A leaf as root has its branches followed, so every bit can emit a symbol.
  task automatic test_leaf_root();
    settle_idle();
    write_register(REG_ROOT, 2);
    decode_byte(8'h96);
    settle_idle();
    write_register(REG_ROOT, 0);
    decode_byte(8'h3C);
  endtask

  // The bit budget runs out at zero, then partway through a byte.
  task automatic test_stream_limit();
    settle_idle();
    write_register(REG_TOTAL, 0);
    decode_byte(8'h5A);
    settle_idle();
    write_register(REG_TOTAL, bits_consumed + 3);
    decode_byte(8'hFF);
    decode_byte(8'h00);
    settle_idle();
    write_register(REG_TOTAL, ALL_BITS);
  endtask

  // Random trees at random places, then runs of random coded bytes with a few
  // stray node writes and full drains mixed in.
  task automatic test_random_trees();
    int phase;
    int leaves;
    int base;
    int n_bytes;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      leaves = (phase == 1) ? 64 : $urandom_range(2, 12);
      base = $urandom_range(0, TREE_NODES - (2 * leaves - 1));
      quiet_mode = 1'b0;
      settle_idle();
      build_code_tree(leaves, base);
      settle_idle();
      if ($urandom_range(0, 4) == 0) write_register(REG_ROOT, CFG_DATA_W'(pick_written()));
      else write_register(REG_ROOT, CFG_DATA_W'(base + 2 * leaves - 2));
      if ($urandom_range(0, 3) == 0)
        write_register(REG_TOTAL, bits_consumed + CFG_DATA_W'($urandom_range(0, 60)));
      else
        write_register(REG_TOTAL, ALL_BITS);
      quiet_mode = (phase % 3 == 2);
      n_bytes = $urandom_range(20, 40);
      for (int k = 0; k < n_bytes && items_sent < ITEM_TARGET; k++) begin
        case ($urandom_range(0, 19))
          0: load_node(NODE_W'($urandom_range(0, 510)), pick_written(), pick_written(),
                       1'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)));
          1: settle_idle();
          default: decode_byte(BYTE_W'($urandom_range(0, 255)));
        endcase
      end
      phase++;
    end
    quiet_mode = 1'b0;
  endtask

  // Result side: a random stall before each output transaction, none in quiet mode.
  initial begin : result_sink
    int stall;
    @(posedge clk);
    forever begin
      stall = quiet_mode ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Compare each output transaction with the oldest expected symbol.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_symbols.size() == 0) begin
        $error("unexpected output transaction: decoded_symbol 0x%0h run_last %0b",
               out_tdata, out_tlast);
        error_count++;
      end else begin
        want = expected_symbols.pop_front();
        if (out_tdata !== want.sym) begin
          $error("decoded_symbol: expected 0x%0h, actual 0x%0h", want.sym, out_tdata);
          error_count++;
        end
        if (out_tlast !== want.is_last) begin
          $error("run_last: expected %0b, actual %0b", want.is_last, out_tlast);
          error_count++;
        end
        symbols_checked++;
      end
    end
  end

  // End the run when no transaction of any kind moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: no transaction for %0d cycles, %0d symbols outstanding",
             STALL_LIMIT, expected_symbols.size());
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    for (int i = 0; i < TREE_NODES; i++) begin
      tree_copy[i] = '0;
      node_written[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_limit();
    test_small_tree();
    test_root_change();
    test_leaf_root();
    test_stream_limit();
    test_random_trees();
    settle_idle();
    $display("Sent %0d node loads and %0d coded bytes, checked %0d symbols, %0d register writes.",
             loads_sent, bytes_sent, symbols_checked, cfg_writes);
    $display("Walked %0d random code trees of up to %0d leaves.", trees_built, largest_tree);
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
